FILE: src/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the grid bilinear sampler: opcodes, status
// codes, fraction constants and the item record passed from front to back.
// ----------------------------------------------------------------------------
package gbs_pkg;

   // Default grid size
   localparam int DEF_MAX_X_POINTS = 64;
   localparam int DEF_MAX_Y_POINTS = 64;
   localparam int QUEUE_DEPTH      = 2;

   // Opcodes
   localparam logic [1:0] OP_WR_X  = 2'd0;
   localparam logic [1:0] OP_WR_Y  = 2'd1;
   localparam logic [1:0] OP_WR_H  = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_NODATA = 2'd2;

   // Configuration register indexes
   localparam logic CSR_X_POINTS = 1'b0;
   localparam logic CSR_Y_POINTS = 1'b1;

   // Q0.16 fraction, held in 17 bits so that one is representable
   localparam int         FRAC_W    = 17;
   localparam logic [16:0] FRAC_ONE  = 17'h10000;
   localparam logic [16:0] FRAC_HALF = 17'h08000;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [11:0]        write_index;
      logic signed [31:0] write_value;
      logic               write_has_data;
      logic signed [31:0] query_x;
      logic signed [31:0] query_y;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic clearing;
   } back_stat_type;

endpackage

FILE: src/gbs_if.sv
// ----------------------------------------------------------------------------
// gbs_req_if / gbs_rsp_if
// Valid/ready channels of the sampler: request beats in, result beats out.
// ----------------------------------------------------------------------------
interface gbs_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [11:0]        write_index;
   logic signed [31:0] write_value;
   logic               write_has_data;
   logic signed [31:0] query_x;
   logic signed [31:0] query_y;

   modport source (output valid, opcode, write_index, write_value, write_has_data,
                   query_x, query_y, input ready);
   modport sink   (input valid, opcode, write_index, write_value, write_has_data,
                   query_x, query_y, output ready);
endinterface

interface gbs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample;
   logic [1:0]         status;

   modport source (output valid, sample, status, input ready);
   modport sink   (input valid, sample, status, output ready);
endinterface

FILE: src/gbs_ram.sv
// ----------------------------------------------------------------------------
// gbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/gbs_queue.sv
// ----------------------------------------------------------------------------
// gbs_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module gbs_queue #(
   parameter int DEPTH = gbs_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  gbs_pkg::push_type push,
   input  logic              pop,
   output gbs_pkg::item_type head,
   output logic              full,
   output logic              empty
);
   import gbs_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

FILE: src/gbs_front.sv
// ----------------------------------------------------------------------------
// gbs_front
// Accepts request beats, drops writes whose index falls outside the stores,
// and pushes the rest into the item queue.
// ----------------------------------------------------------------------------
module gbs_front #(
   parameter int MAX_X_POINTS = gbs_pkg::DEF_MAX_X_POINTS,
   parameter int MAX_Y_POINTS = gbs_pkg::DEF_MAX_Y_POINTS
) (
   gbs_req_if.sink                req_if,
   input  gbs_pkg::back_stat_type back_stat,
   input  logic                   q_full,
   output gbs_pkg::push_type      push
);
   import gbs_pkg::*;

   localparam int CELLS = MAX_X_POINTS * MAX_Y_POINTS;

   logic [31:0] widx;
   logic        accept;
   logic        keep;

   assign req_if.ready = !q_full && !back_stat.clearing;
   assign accept       = req_if.valid && req_if.ready;
   assign widx         = 32'(req_if.write_index);

   // Classify: writes beyond their store are dropped here
   always_comb begin
      unique case (req_if.opcode)
         OP_WR_X:  keep = (widx < 32'(MAX_X_POINTS));
         OP_WR_Y:  keep = (widx < 32'(MAX_Y_POINTS));
         OP_WR_H:  keep = (widx < 32'(CELLS));
         OP_QUERY: keep = 1'b1;
         default:  keep = 1'b0;
      endcase
   end

   assign push.valid                     = accept && keep;
   assign push.item.opcode               = req_if.opcode;
   assign push.item.write_index          = req_if.write_index;
   assign push.item.write_value          = req_if.write_value;
   assign push.item.write_has_data       = req_if.write_has_data;
   assign push.item.query_x              = req_if.query_x;
   assign push.item.query_y              = req_if.query_y;

endmodule

FILE: src/gbs_back.sv
// ----------------------------------------------------------------------------
// gbs_back
// Executes queued items: store writes, and queries (axis search, fraction
// division, corner reads, top/bottom/final blend). Also clears the valid bits
// after reset.
// ----------------------------------------------------------------------------
module gbs_back #(
   parameter int MAX_X_POINTS = gbs_pkg::DEF_MAX_X_POINTS,
   parameter int MAX_Y_POINTS = gbs_pkg::DEF_MAX_Y_POINTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  gbs_pkg::item_type      head,
   output logic                   pop,
   input  logic [6:0]             x_points,
   input  logic [6:0]             y_points,
   output gbs_pkg::back_stat_type stat,
   gbs_rsp_if.source              rsp_if
);
   import gbs_pkg::*;

   localparam int XAW   = $clog2(MAX_X_POINTS);
   localparam int YAW   = $clog2(MAX_Y_POINTS);
   localparam int MAXP  = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
   localparam int NW    = $clog2(MAXP + 1);
   localparam int CELLS = MAX_X_POINTS * MAX_Y_POINTS;
   localparam int CW    = $clog2(CELLS);

   // Sequencer states
   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_E0    = 5'd2;
   localparam logic [4:0] S_E1    = 5'd3;
   localparam logic [4:0] S_E2    = 5'd4;
   localparam logic [4:0] S_SA    = 5'd5;
   localparam logic [4:0] S_SC    = 5'd6;
   localparam logic [4:0] S_CA    = 5'd7;
   localparam logic [4:0] S_CB    = 5'd8;
   localparam logic [4:0] S_CC    = 5'd9;
   localparam logic [4:0] S_PREP  = 5'd10;
   localparam logic [4:0] S_DIV   = 5'd11;
   localparam logic [4:0] S_H0    = 5'd12;
   localparam logic [4:0] S_H1    = 5'd13;
   localparam logic [4:0] S_H2    = 5'd14;
   localparam logic [4:0] S_H3    = 5'd15;
   localparam logic [4:0] S_H4    = 5'd16;
   localparam logic [4:0] S_NEAR  = 5'd17;
   localparam logic [4:0] S_BM0   = 5'd18;
   localparam logic [4:0] S_BM1   = 5'd19;
   localparam logic [4:0] S_BSUM  = 5'd20;
   localparam logic [4:0] S_DONE  = 5'd21;

   // Blend stages
   localparam logic [1:0] BL_TOP = 2'd0;
   localparam logic [1:0] BL_BOT = 2'd1;
   localparam logic [1:0] BL_FIN = 2'd2;

   logic [4:0]         state_ff;
   logic [CW-1:0]      clr_cnt_ff;

   // Per-axis lanes: 0 is x, 1 is y
   logic signed [31:0] v_ff     [2];
   logic signed [31:0] first_ff [2];
   logic [NW-1:0]      lo_ff    [2];
   logic [NW-1:0]      hi_ff    [2];
   logic [NW-1:0]      mid_ff   [2];
   logic               asc_ff   [2];
   logic [NW-1:0]      cell_ff  [2];
   logic signed [31:0] c0_ff    [2];
   logic signed [31:0] c1_ff    [2];
   logic [31:0]        rem_ff   [2];
   logic [31:0]        den_ff   [2];
   logic [15:0]        q_ff     [2];
   logic [16:0]        frac_ff  [2];
   logic               dact_ff  [2];
   logic [3:0]         div_cnt_ff;

   logic [NW-1:0]      lane_n    [2];
   logic [NW-1:0]      rd_idx    [2];
   logic [NW-1:0]      mid_calc  [2];
   logic [NW-1:0]      cell_calc [2];
   logic               active    [2];
   logic               in_range  [2];
   logic signed [31:0] rdata     [2];
   logic [31:0]        rem_next  [2];
   logic [15:0]        q_next    [2];

   logic [31:0]        x_rd, y_rd;
   logic [31:0]        widx;
   logic               x_wr_en, y_wr_en, h_wr_en;
   logic [CW-1:0]      h_wr_addr, h_rd_addr;
   logic [32:0]        h_wr_data, h_rd;

   logic [CW-1:0]      base_ff;
   logic [31:0]        base_calc;
   logic [32:0]        h_ff [4];

   logic [1:0]         stage_ff;
   logic signed [49:0] prod_ff, acc_ff;
   logic signed [49:0] prod_in, sum;
   logic signed [33:0] blend_res;
   logic signed [31:0] top_blend_ff, bot_blend_ff;
   logic signed [31:0] top_sel, bot_sel;
   logic signed [31:0] mul_a;
   logic [16:0]        mul_w;
   logic               v00, v10, v01, v11, vt, vb;
   logic [1:0]         near;
   logic signed [33:0] fin_val;
   logic signed [31:0] fin_sat;

   logic signed [31:0] res_sample_ff;
   logic [1:0]         res_status_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_sample_ff;
   logic [1:0]         rsp_status_ff;

   // Stores
   assign widx    = 32'(head.write_index);
   assign pop     = (state_ff == S_IDLE) && !q_empty;
   assign x_wr_en = pop && (head.opcode == OP_WR_X);
   assign y_wr_en = pop && (head.opcode == OP_WR_Y);
   assign h_wr_en = (state_ff == S_CLEAR) || (pop && (head.opcode == OP_WR_H));
   assign h_wr_addr = (state_ff == S_CLEAR) ? clr_cnt_ff : widx[CW-1:0];
   assign h_wr_data = (state_ff == S_CLEAR) ? '0 :
                      {head.write_has_data, head.write_value};

   gbs_ram #(.WIDTH(32), .DEPTH(MAX_X_POINTS)) u_x_ram (
      .clock   (clock),
      .wr_en   (x_wr_en),
      .wr_addr (widx[XAW-1:0]),
      .wr_data (head.write_value),
      .rd_addr (rd_idx[0][XAW-1:0]),
      .rd_data (x_rd)
   );

   gbs_ram #(.WIDTH(32), .DEPTH(MAX_Y_POINTS)) u_y_ram (
      .clock   (clock),
      .wr_en   (y_wr_en),
      .wr_addr (widx[YAW-1:0]),
      .wr_data (head.write_value),
      .rd_addr (rd_idx[1][YAW-1:0]),
      .rd_data (y_rd)
   );

   // Height and valid bit share one word
   gbs_ram #(.WIDTH(33), .DEPTH(CELLS)) u_h_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd)
   );

   assign rdata[0] = $signed(x_rd);
   assign rdata[1] = $signed(y_rd);

   // Clamp entry counts to the store depth
   assign lane_n[0] = (32'(x_points) > 32'(MAX_X_POINTS)) ? NW'(MAX_X_POINTS) : NW'(x_points);
   assign lane_n[1] = (32'(y_points) > 32'(MAX_Y_POINTS)) ? NW'(MAX_Y_POINTS) : NW'(y_points);

   // Lane address and search logic
   always_comb begin
      logic [NW-1:0]      idx;
      logic signed [31:0] lo_end, hi_end;
      logic               asc;
      logic [32:0]        shifted;
      for (int l = 0; l < 2; l++) begin
         active[l]   = (lo_ff[l] < hi_ff[l]);
         mid_calc[l] = lo_ff[l] + ((hi_ff[l] - lo_ff[l]) >> 1);

         // Upper bound minus one, clamped, mirrored for descending axes
         idx = (lo_ff[l] == '0) ? '0 : lo_ff[l] - NW'(1);
         if (idx > lane_n[l] - NW'(2)) begin
            idx = lane_n[l] - NW'(2);
         end
         cell_calc[l] = asc_ff[l] ? idx : lane_n[l] - NW'(2) - idx;

         // Range test against the ends of the axis
         asc    = rdata[l] > first_ff[l];
         lo_end = asc ? first_ff[l] : rdata[l];
         hi_end = asc ? rdata[l] : first_ff[l];
         in_range[l] = (lane_n[l] >= NW'(2)) && (v_ff[l] >= lo_end) && (v_ff[l] <= hi_end);

         // One restoring division step
         shifted = {rem_ff[l], 1'b0};
         if (shifted >= {1'b0, den_ff[l]}) begin
            rem_next[l] = 32'(shifted - {1'b0, den_ff[l]});
            q_next[l]   = {q_ff[l][14:0], 1'b1};
         end else begin
            rem_next[l] = shifted[31:0];
            q_next[l]   = {q_ff[l][14:0], 1'b0};
         end

         unique case (state_ff)
            S_E1:    rd_idx[l] = (lane_n[l] >= NW'(2)) ? lane_n[l] - NW'(1) : '0;
            S_SA:    rd_idx[l] = asc_ff[l] ? mid_calc[l] : lane_n[l] - NW'(1) - mid_calc[l];
            S_CA:    rd_idx[l] = cell_ff[l];
            S_CB:    rd_idx[l] = cell_ff[l] + NW'(1);
            default: rd_idx[l] = '0;
         endcase
      end
   end

   // Corner addresses
   assign base_calc = 32'(cell_ff[1]) * 32'(MAX_X_POINTS) + 32'(cell_ff[0]);

   always_comb begin
      unique case (state_ff)
         S_H1:    h_rd_addr = base_ff + CW'(1);
         S_H2:    h_rd_addr = base_ff + CW'(MAX_X_POINTS);
         S_H3:    h_rd_addr = base_ff + CW'(MAX_X_POINTS + 1);
         default: h_rd_addr = base_ff;
      endcase
   end

   // Corner validity and fallback selection
   assign v00  = h_ff[0][32];
   assign v10  = h_ff[1][32];
   assign v01  = h_ff[2][32];
   assign v11  = h_ff[3][32];
   assign vt   = v00 || v10;
   assign vb   = v01 || v11;
   assign near = {frac_ff[1] > FRAC_HALF, frac_ff[0] > FRAC_HALF};

   assign top_sel = (v00 && v10) ? top_blend_ff :
                    v00 ? $signed(h_ff[0][31:0]) : $signed(h_ff[1][31:0]);
   assign bot_sel = (v01 && v11) ? bot_blend_ff :
                    v01 ? $signed(h_ff[2][31:0]) : $signed(h_ff[3][31:0]);

   // Shared multiplier operands
   always_comb begin
      unique case (stage_ff)
         BL_TOP: begin
            mul_a = (state_ff == S_BM0) ? $signed(h_ff[0][31:0]) : $signed(h_ff[1][31:0]);
            mul_w = (state_ff == S_BM0) ? FRAC_ONE - frac_ff[0] : frac_ff[0];
         end
         BL_BOT: begin
            mul_a = (state_ff == S_BM0) ? $signed(h_ff[2][31:0]) : $signed(h_ff[3][31:0]);
            mul_w = (state_ff == S_BM0) ? FRAC_ONE - frac_ff[0] : frac_ff[0];
         end
         default: begin
            mul_a = (state_ff == S_BM0) ? top_sel : bot_sel;
            mul_w = (state_ff == S_BM0) ? FRAC_ONE - frac_ff[1] : frac_ff[1];
         end
      endcase
   end

   assign prod_in   = mul_a * $signed({1'b0, mul_w});
   assign sum       = acc_ff + prod_ff + 50'sd32768;
   assign blend_res = sum[49:16];

   // Pick the final value and saturate
   always_comb begin
      if (vt && vb) begin
         fin_val = blend_res;
      end else begin
         fin_val = vt ? 34'(top_sel) : 34'(bot_sel);
      end
      if (fin_val > 34'sd2147483647) begin
         fin_sat = 32'sh7fffffff;
      end else if (fin_val < -34'sd2147483648) begin
         fin_sat = 32'sh80000000;
      end else begin
         fin_sat = fin_val[31:0];
      end
   end

   // Sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Load the result register when it frees up, drop valid once taken
         if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + CW'(1);
               if (clr_cnt_ff == CW'(CELLS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop && (head.opcode == OP_QUERY)) begin
                  state_ff <= S_E0;
               end
            end
            S_E0:   state_ff <= S_E1;
            S_E1:   state_ff <= S_E2;
            S_E2:   state_ff <= (in_range[0] && in_range[1]) ? S_SA : S_DONE;
            S_SA:   state_ff <= (active[0] || active[1]) ? S_SC : S_CA;
            S_SC:   state_ff <= S_SA;
            S_CA:   state_ff <= S_CB;
            S_CB:   state_ff <= S_CC;
            S_CC:   state_ff <= S_PREP;
            S_PREP: state_ff <= S_DIV;
            S_DIV: begin
               if (div_cnt_ff == 4'd15) begin
                  state_ff <= S_H0;
               end
            end
            S_H0:   state_ff <= S_H1;
            S_H1:   state_ff <= S_H2;
            S_H2:   state_ff <= S_H3;
            S_H3:   state_ff <= S_H4;
            S_H4:   state_ff <= S_NEAR;
            S_NEAR: state_ff <= (!h_ff[near][32] || (!vt && !vb)) ? S_DONE : S_BM0;
            S_BM0:  state_ff <= S_BM1;
            S_BM1:  state_ff <= S_BSUM;
            S_BSUM: state_ff <= (stage_ff == BL_FIN) ? S_DONE : S_BM0;
            S_DONE: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Sequencer datapath
   always_ff @(posedge clock) begin
      logic signed [33:0] num, den, num_m, den_m;
      unique case (state_ff)
         S_IDLE: begin
            v_ff[0]  <= head.query_x;
            v_ff[1]  <= head.query_y;
            stage_ff <= BL_TOP;
         end
         S_E1: begin
            for (int l = 0; l < 2; l++) first_ff[l] <= rdata[l];
         end
         S_E2: begin
            for (int l = 0; l < 2; l++) begin
               asc_ff[l] <= rdata[l] > first_ff[l];
               lo_ff[l]  <= '0;
               hi_ff[l]  <= lane_n[l];
            end
            res_status_ff <= ST_RANGE;
            res_sample_ff <= '0;
         end
         S_SA: begin
            for (int l = 0; l < 2; l++) begin
               mid_ff[l]  <= mid_calc[l];
               cell_ff[l] <= cell_calc[l];
            end
         end
         S_SC: begin
            for (int l = 0; l < 2; l++) begin
               if (active[l]) begin
                  if (rdata[l] <= v_ff[l]) begin
                     lo_ff[l] <= mid_ff[l] + NW'(1);
                  end else begin
                     hi_ff[l] <= mid_ff[l];
                  end
               end
            end
         end
         S_CB: begin
            for (int l = 0; l < 2; l++) c0_ff[l] <= rdata[l];
            base_ff <= base_calc[CW-1:0];
         end
         S_CC: begin
            for (int l = 0; l < 2; l++) c1_ff[l] <= rdata[l];
         end
         S_PREP: begin
            // Set up each fraction: special cases settle at once
            for (int l = 0; l < 2; l++) begin
               num   = 34'(v_ff[l]) - 34'(c0_ff[l]);
               den   = 34'(c1_ff[l]) - 34'(c0_ff[l]);
               num_m = (den < 0) ? -num : num;
               den_m = (den < 0) ? -den : den;
               rem_ff[l]  <= num_m[31:0];
               den_ff[l]  <= den_m[31:0];
               q_ff[l]    <= '0;
               if (den == 0 || num_m <= 0) begin
                  frac_ff[l] <= '0;
                  dact_ff[l] <= 1'b0;
               end else if (num_m >= den_m) begin
                  frac_ff[l] <= FRAC_ONE;
                  dact_ff[l] <= 1'b0;
               end else begin
                  frac_ff[l] <= '0;
                  dact_ff[l] <= 1'b1;
               end
            end
            div_cnt_ff <= '0;
         end
         S_DIV: begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[l] <= rem_next[l];
               q_ff[l]   <= q_next[l];
               if (div_cnt_ff == 4'd15 && dact_ff[l]) begin
                  frac_ff[l] <= {1'b0, q_next[l]};
               end
            end
            div_cnt_ff <= div_cnt_ff + 4'd1;
         end
         S_H1: h_ff[0] <= h_rd;
         S_H2: h_ff[1] <= h_rd;
         S_H3: h_ff[2] <= h_rd;
         S_H4: h_ff[3] <= h_rd;
         S_NEAR: begin
            res_status_ff <= ST_NODATA;
            res_sample_ff <= '0;
         end
         S_BM0: prod_ff <= prod_in;
         S_BM1: begin
            acc_ff  <= prod_ff;
            prod_ff <= prod_in;
         end
         S_BSUM: begin
            // Convex blend stays inside the range of its two corners
            unique case (stage_ff)
               BL_TOP: top_blend_ff <= blend_res[31:0];
               BL_BOT: bot_blend_ff <= blend_res[31:0];
               default: begin
                  res_status_ff <= ST_OK;
                  res_sample_ff <= fin_sat;
               end
            endcase
            stage_ff <= stage_ff + 2'd1;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_sample_ff <= res_sample_ff;
               rsp_status_ff <= res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign stat.clearing = (state_ff == S_CLEAR);

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = rsp_sample_ff;
   assign rsp_if.status = rsp_status_ff;

   // Checks
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !pop)
      else $error("item taken during clearing pass");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (pop && head.opcode == OP_QUERY) |=> (state_ff == S_E0))
      else $error("query did not start the axis search");

   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEAR) |-> (frac_ff[0] <= FRAC_ONE && frac_ff[1] <= FRAC_ONE))
      else $error("fraction above one");

   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_sample_ff == '0))
      else $error("nonzero sample with failing status");

endmodule

FILE: src/grid_bilinear_sampler_core.sv
// ----------------------------------------------------------------------------
// grid_bilinear_sampler_core
// Bilinear height sampling on a rectilinear grid with per-cell no-data marks.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  req_if  | in  | opcode, write_index, write_value, write_has_data, query
//  rsp_if  | out | sample, status (one beat per query, none for writes)
//  csr_*   | in  | csr_index selects x_points / y_points, csr_data value
//
//  A query on both axes runs parallel axis searches, one divider pass for
//  both fractions, four height reads and three blends on one multiplier.
//  Off-axis queries answer once the axis ends are read; no-data skips blends.
//  After reset a clearing pass over all MAX_X_POINTS*MAX_Y_POINTS cells
//  holds req_if.ready low. A two-entry queue takes beats while the back is
//  busy.
// ----------------------------------------------------------------------------
module grid_bilinear_sampler_core #(
   parameter int MAX_X_POINTS = gbs_pkg::DEF_MAX_X_POINTS,
   parameter int MAX_Y_POINTS = gbs_pkg::DEF_MAX_Y_POINTS
) (
   input  logic       clock,
   input  logic       reset,
   gbs_req_if.sink    req_if,
   gbs_rsp_if.source  rsp_if,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [6:0] csr_data
);
   import gbs_pkg::*;

   logic [6:0]    x_points_ff, y_points_ff;
   push_type      push;
   item_type      head;
   logic          q_full, q_empty, pop;
   back_stat_type back_stat;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_points_ff <= '0;
         y_points_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_X_POINTS: x_points_ff <= csr_data;
            CSR_Y_POINTS: y_points_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   gbs_front #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS)) u_front (
      .req_if    (req_if),
      .back_stat (back_stat),
      .q_full    (q_full),
      .push      (push)
   );

   gbs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full),
      .empty (q_empty)
   );

   gbs_back #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head     (head),
      .pop      (pop),
      .x_points (x_points_ff),
      .y_points (y_points_ff),
      .stat     (back_stat),
      .rsp_if   (rsp_if)
   );

endmodule
